@@ src/eic_pkg.sv @@
`timescale 1ns / 1ps
package eic_pkg;

  localparam int LINE_MAX       = 16;
  localparam int LINE_COUNT_DEF = 16;
  localparam int PORT_COUNT     = 8;
  localparam int PORT_SEL_W     = $clog2(PORT_COUNT);
  localparam int PIN_W          = 16;
  localparam int ROUTE_W        = 8;
  localparam int DATA_W         = 32;
  localparam int ROUTES_PER_REG = DATA_W / ROUTE_W;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_READ   = 2'd1,
    FN_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    REG_RISE_EN   = 4'd0,
    REG_FALL_EN   = 4'd1,
    REG_RISE_PEND = 4'd2,
    REG_FALL_PEND = 4'd3,
    REG_MASK      = 4'd4,
    REG_ROUTE0    = 4'd5,
    REG_ROUTE1    = 4'd6,
    REG_ROUTE2    = 4'd7,
    REG_ROUTE3    = 4'd8
  } reg_code_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        reg_sel;
    logic [DATA_W-1:0] write_data;
    logic [PIN_W-1:0]  port_a_pins;
    logic [PIN_W-1:0]  port_b_pins;
    logic [PIN_W-1:0]  port_c_pins;
    logic [PIN_W-1:0]  port_d_pins;
    logic [PIN_W-1:0]  port_e_pins;
    logic [PIN_W-1:0]  port_f_pins;
    logic [PIN_W-1:0]  port_g_pins;
    logic [PIN_W-1:0]  port_h_pins;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [PIN_W-1:0]  irq_lines;
  } rsp_t;

  // Bus command as seen by every lane.
  typedef struct packed {
    logic              accept;
    logic [1:0]        func;
    logic [3:0]        reg_sel;
    logic [DATA_W-1:0] write_data;
  } lane_cmd_t;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic               rise_en;
    logic               fall_en;
    logic               rise_pend;
    logic               fall_pend;
    logic               mask;
    logic               irq_next;
    logic [ROUTE_W-1:0] route;
  } lane_stat_t;

endpackage

@@ src/eic_chan_if.sv @@
`timescale 1ns / 1ps
interface eic_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/external_interrupt_edge_controller.sv @@
`timescale 1ns / 1ps
// External interrupt controller for up to sixteen lines, each routed to one of
// eight GPIO ports. Every word on bus_req is a register write, a register read
// or a pin sample tick, and produces exactly one word on bus_rsp carrying the
// read data (zero unless a read) and the masked interrupt lines after the word
// has been applied.
// One lane per line holds that line's enables, pending bits, mask, selector
// and last level; a merge stage gathers the lanes into the read data and the
// interrupt vector, and a single output register holds the result.
// The result shows on bus_rsp in the cycle after acceptance.
// Throughput is one word per cycle, set by the output register: a new word is
// taken whenever that register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and bus_req.ready drops until the
// result is taken. Reset clears every lane register and the output valid flag:
// no trigger enabled, nothing pending, all lines masked and routed to port 0,
// last levels low, and the output register empty.
module external_interrupt_edge_controller #(
  parameter int LINE_COUNT = eic_pkg::LINE_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  eic_chan_if.sink   bus_req,
  eic_chan_if.source bus_rsp
);
  import eic_pkg::*;

  logic                                  in_acc;
  lane_cmd_t                             cmd;
  logic [PORT_COUNT-1:0][PIN_W-1:0]      ports;
  logic [LINE_COUNT-1:0][PORT_COUNT-1:0] lane_pins;
  lane_stat_t [LINE_COUNT-1:0]           lane_stats;
  logic [DATA_W-1:0]                     read_data;
  logic [PIN_W-1:0]                      irq_lines;
  logic [PIN_W-1:0]                      mask_now;
  logic                                  rsp_valid;
  rsp_t                                  rsp_word;

  assign bus_req.ready = !rsp_valid || bus_rsp.ready;
  assign in_acc        = bus_req.valid && bus_req.ready;

  always_comb begin
    cmd.accept     = in_acc;
    cmd.func       = bus_req.payload.func;
    cmd.reg_sel    = bus_req.payload.reg_sel;
    cmd.write_data = bus_req.payload.write_data;
    ports[0]       = bus_req.payload.port_a_pins;
    ports[1]       = bus_req.payload.port_b_pins;
    ports[2]       = bus_req.payload.port_c_pins;
    ports[3]       = bus_req.payload.port_d_pins;
    ports[4]       = bus_req.payload.port_e_pins;
    ports[5]       = bus_req.payload.port_f_pins;
    ports[6]       = bus_req.payload.port_g_pins;
    ports[7]       = bus_req.payload.port_h_pins;
    for (int l = 0; l < LINE_COUNT; l++) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        lane_pins[l][p] = ports[p][l];
      end
    end
  end

  for (genvar g = 0; g < LINE_COUNT; g++) begin : g_lane
    eic_lane #(
      .LINE (g)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .pins (lane_pins[g]),
      .stat (lane_stats[g])
    );
  end

  eic_merge #(
    .LINE_COUNT (LINE_COUNT)
  ) u_merge (
    .lanes     (lane_stats),
    .func      (bus_req.payload.func),
    .reg_sel   (bus_req.payload.reg_sel),
    .read_data (read_data),
    .irq_lines (irq_lines)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (in_acc) begin
      rsp_valid <= 1'b1;
    end else if (bus_rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rsp_word.read_data <= read_data;
      rsp_word.irq_lines <= irq_lines;
    end
  end

  assign bus_rsp.valid   = rsp_valid;
  assign bus_rsp.payload = rsp_word;

  always_comb begin
    mask_now = '0;
    for (int l = 0; l < LINE_COUNT; l++) begin
      mask_now[l] = lane_stats[l].mask;
    end
  end

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    in_acc && bus_req.payload.func != FN_READ |=> bus_rsp.payload.read_data == '0)
    else $error("read data not zero after a non-read word");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> bus_rsp.valid)
    else $error("accepted word gave no result");

  a_irq_masked: assert property (@(posedge clk) disable iff (rst)
    bus_rsp.valid |-> (bus_rsp.payload.irq_lines & ~mask_now) == '0)
    else $error("interrupt line raised on a masked line");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !bus_rsp.valid)
    else $error("result valid right after reset");

endmodule

@@ src/eic_lane.sv @@
`timescale 1ns / 1ps
module eic_lane #(
  parameter int LINE = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  eic_pkg::lane_cmd_t                  cmd,
  input  logic [eic_pkg::PORT_COUNT-1:0]      pins,
  output eic_pkg::lane_stat_t                 stat
);
  import eic_pkg::*;

  localparam logic [3:0] ROUTE_CODE = 4'(REG_ROUTE0) + 4'(LINE / ROUTES_PER_REG);
  localparam int         BYTE_LO    = ROUTE_W * (LINE % ROUTES_PER_REG);

  logic               rise_en, rise_en_next;
  logic               fall_en, fall_en_next;
  logic               rise_pend, rise_pend_next;
  logic               fall_pend, fall_pend_next;
  logic               mask, mask_next;
  logic               last_level, last_level_next;
  logic [ROUTE_W-1:0] route, route_next;
  logic               level;
  logic               wbit;

  always_comb begin
    wbit            = cmd.write_data[LINE];
    level           = (route < ROUTE_W'(PORT_COUNT)) ? pins[route[PORT_SEL_W-1:0]] : 1'b0;
    rise_en_next    = rise_en;
    fall_en_next    = fall_en;
    rise_pend_next  = rise_pend;
    fall_pend_next  = fall_pend;
    mask_next       = mask;
    last_level_next = last_level;
    route_next      = route;
    if (cmd.accept) begin
      case (cmd.func)
        FN_WRITE: begin
          case (cmd.reg_sel)
            REG_RISE_EN:   rise_en_next   = wbit;
            REG_FALL_EN:   fall_en_next   = wbit;
            REG_RISE_PEND: rise_pend_next = rise_pend & ~wbit;
            REG_FALL_PEND: fall_pend_next = fall_pend & ~wbit;
            REG_MASK:      mask_next      = wbit;
            default: begin
              if (cmd.reg_sel == ROUTE_CODE) begin
                route_next = cmd.write_data[BYTE_LO +: ROUTE_W];
              end
            end
          endcase
        end
        FN_SAMPLE: begin
          rise_pend_next  = rise_pend | (level & ~last_level & rise_en);
          fall_pend_next  = fall_pend | (~level & last_level & fall_en);
          last_level_next = level;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_en    <= 1'b0;
      fall_en    <= 1'b0;
      rise_pend  <= 1'b0;
      fall_pend  <= 1'b0;
      mask       <= 1'b0;
      last_level <= 1'b0;
      route      <= '0;
    end else begin
      rise_en    <= rise_en_next;
      fall_en    <= fall_en_next;
      rise_pend  <= rise_pend_next;
      fall_pend  <= fall_pend_next;
      mask       <= mask_next;
      last_level <= last_level_next;
      route      <= route_next;
    end
  end

  always_comb begin
    stat.rise_en   = rise_en;
    stat.fall_en   = fall_en;
    stat.rise_pend = rise_pend;
    stat.fall_pend = fall_pend;
    stat.mask      = mask;
    stat.route     = route;
    stat.irq_next  = (rise_pend_next | fall_pend_next) & mask_next;
  end

endmodule

@@ src/eic_merge.sv @@
`timescale 1ns / 1ps
module eic_merge #(
  parameter int LINE_COUNT = eic_pkg::LINE_COUNT_DEF
) (
  input  eic_pkg::lane_stat_t [LINE_COUNT-1:0] lanes,
  input  logic [1:0]                           func,
  input  logic [3:0]                           reg_sel,
  output logic [eic_pkg::DATA_W-1:0]           read_data,
  output logic [eic_pkg::PIN_W-1:0]            irq_lines
);
  import eic_pkg::*;

  logic [LINE_MAX-1:0] rise_en_v, fall_en_v, rise_pend_v, fall_pend_v, mask_v;
  logic [DATA_W-1:0]   route_v;

  always_comb begin
    rise_en_v   = '0;
    fall_en_v   = '0;
    rise_pend_v = '0;
    fall_pend_v = '0;
    mask_v      = '0;
    irq_lines   = '0;
    route_v     = '0;
    for (int l = 0; l < LINE_COUNT; l++) begin
      rise_en_v[l]   = lanes[l].rise_en;
      fall_en_v[l]   = lanes[l].fall_en;
      rise_pend_v[l] = lanes[l].rise_pend;
      fall_pend_v[l] = lanes[l].fall_pend;
      mask_v[l]      = lanes[l].mask;
      irq_lines[l]   = lanes[l].irq_next;
      // Each route register gathers the selectors of four consecutive lines.
      if (reg_sel == 4'(REG_ROUTE0) + 4'(l / ROUTES_PER_REG)) begin
        route_v[ROUTE_W * (l % ROUTES_PER_REG) +: ROUTE_W] = lanes[l].route;
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (func == FN_READ) begin
      case (reg_sel)
        REG_RISE_EN:   read_data = DATA_W'(rise_en_v);
        REG_FALL_EN:   read_data = DATA_W'(fall_en_v);
        REG_RISE_PEND: read_data = DATA_W'(rise_pend_v);
        REG_FALL_PEND: read_data = DATA_W'(fall_pend_v);
        REG_MASK:      read_data = DATA_W'(mask_v);
        REG_ROUTE0, REG_ROUTE1, REG_ROUTE2, REG_ROUTE3: read_data = route_v;
        default:       read_data = '0;
      endcase
    end
  end

endmodule

@@ verif/tb_external_interrupt_edge_controller.sv @@
`timescale 1ns / 1ps
module tb_external_interrupt_edge_controller;
  import eic_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT  = 250000;

  // Codes that the block decodes as nothing.
  localparam logic [1:0] FN_UNUSED   = 2'd3;
  localparam logic [3:0] REG_NONE_LO = 4'd9;
  localparam logic [3:0] REG_NONE_HI = 4'd15;

  // Shadow copy of the controller registers and the replies they imply.
  class eic_mirror;
    logic [15:0] rise_en, fall_en, rise_pend, fall_pend, line_mask, last_lvl;
    logic [7:0]  route [16];
    rsp_t        replies_due [$];
    int          errors;

    function new();
      int ln;
      rise_en   = '0;
      fall_en   = '0;
      rise_pend = '0;
      fall_pend = '0;
      line_mask = '0;
      last_lvl  = '0;
      for (ln = 0; ln < 16; ln++) route[ln] = '0;
      errors = 0;
    endfunction

    function void take_request(req_t w);
      logic [7:0][15:0] pins;
      logic [15:0]      lvl;
      logic [31:0]      rd;
      rsp_t             r;
      int               base;
      int               j;
      int               ln;
      pins[0] = w.port_a_pins;
      pins[1] = w.port_b_pins;
      pins[2] = w.port_c_pins;
      pins[3] = w.port_d_pins;
      pins[4] = w.port_e_pins;
      pins[5] = w.port_f_pins;
      pins[6] = w.port_g_pins;
      pins[7] = w.port_h_pins;
      rd = '0;
      if (w.func == FN_WRITE) begin
        case (w.reg_sel)
          REG_RISE_EN:   rise_en   = w.write_data[15:0];
          REG_FALL_EN:   fall_en   = w.write_data[15:0];
          REG_RISE_PEND: rise_pend = rise_pend & ~w.write_data[15:0];
          REG_FALL_PEND: fall_pend = fall_pend & ~w.write_data[15:0];
          REG_MASK:      line_mask = w.write_data[15:0];
          REG_ROUTE0, REG_ROUTE1, REG_ROUTE2, REG_ROUTE3: begin
            base = 4 * (int'(w.reg_sel) - int'(REG_ROUTE0));
            for (j = 0; j < 4; j++) route[base + j] = w.write_data[8*j +: 8];
          end
          default: ;
        endcase
      end else if (w.func == FN_READ) begin
        case (w.reg_sel)
          REG_RISE_EN:   rd = {16'h0, rise_en};
          REG_FALL_EN:   rd = {16'h0, fall_en};
          REG_RISE_PEND: rd = {16'h0, rise_pend};
          REG_FALL_PEND: rd = {16'h0, fall_pend};
          REG_MASK:      rd = {16'h0, line_mask};
          REG_ROUTE0, REG_ROUTE1, REG_ROUTE2, REG_ROUTE3: begin
            base = 4 * (int'(w.reg_sel) - int'(REG_ROUTE0));
            for (j = 0; j < 4; j++) rd[8*j +: 8] = route[base + j];
          end
          default: rd = '0;
        endcase
      end else if (w.func == FN_SAMPLE) begin
        // A selector past the last port makes the line read low.
        lvl = '0;
        for (ln = 0; ln < 16; ln++) begin
          if (route[ln] < PORT_COUNT) lvl[ln] = pins[route[ln][2:0]][ln];
        end
        rise_pend = rise_pend | (lvl & ~last_lvl & rise_en);
        fall_pend = fall_pend | (last_lvl & ~lvl & fall_en);
        last_lvl  = lvl;
      end
      r.read_data = rd;
      r.irq_lines = (rise_pend | fall_pend) & line_mask;
      replies_due.push_back(r);
    endfunction

    function void match_response(rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected word: read_data %h irq_lines %h", got.read_data, got.irq_lines);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.irq_lines !== want.irq_lines) begin
        $error("irq_lines: expected %h, actual %h", want.irq_lines, got.irq_lines);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   burst_left;
  int   stall_phase;
  int   stall_mode;

  eic_mirror mirror;

  eic_chan_if #(.T(req_t)) req_if ();
  eic_chan_if #(.T(rsp_t)) rsp_if ();

  external_interrupt_edge_controller #(
    .LINE_COUNT(LINE_COUNT_DEF)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .bus_req(req_if),
    .bus_rsp(rsp_if)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bus word with throwaway pin levels, which the block must ignore.
  function automatic req_t bus_word(logic [1:0] f, logic [3:0] s, logic [31:0] d);
    req_t w;
    w.func        = f;
    w.reg_sel     = s;
    w.write_data  = d;
    w.port_a_pins = 16'($urandom);
    w.port_b_pins = 16'($urandom);
    w.port_c_pins = 16'($urandom);
    w.port_d_pins = 16'($urandom);
    w.port_e_pins = 16'($urandom);
    w.port_f_pins = 16'($urandom);
    w.port_g_pins = 16'($urandom);
    w.port_h_pins = 16'($urandom);
    return w;
  endfunction

  function automatic req_t tick_word(logic [7:0][15:0] pins);
    req_t w;
    w             = bus_word(FN_SAMPLE, 4'($urandom), $urandom);
    w.port_a_pins = pins[0];
    w.port_b_pins = pins[1];
    w.port_c_pins = pins[2];
    w.port_d_pins = pins[3];
    w.port_e_pins = pins[4];
    w.port_f_pins = pins[5];
    w.port_g_pins = pins[6];
    w.port_h_pins = pins[7];
    return w;
  endfunction

  // The sender runs in bursts; a gap of idle cycles may open before each burst.
  task automatic issue_word(input req_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.payload <= w;
    req_if.valid   <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Receiver switches among four stall patterns: always ready, coin-flip, periodic and mostly stalled.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= 1'($urandom_range(0, 1));
      2:       rsp_if.ready <= (stall_phase % 4) != 3;
      default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Responses are checked before the request of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) mirror.match_response(rsp_if.payload);
      if (req_if.valid && req_if.ready) mirror.take_request(req_if.payload);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [7:0][15:0] pins;
    logic [31:0]      d;
    logic [3:0]       s;
    int               n;
    int               pick;
    int               p;
    int               j;
    mirror         = new();
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    burst_left     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part: route every line (some out of range), enable, tick pins, clear and read back.
    issue_word(bus_word(FN_READ, REG_ROUTE0, 32'h0));
    issue_word(bus_word(FN_WRITE, REG_ROUTE0, 32'h03020100));
    issue_word(bus_word(FN_WRITE, REG_ROUTE1, 32'h07060504));
    issue_word(bus_word(FN_WRITE, REG_ROUTE2, 32'h00FF0800));
    issue_word(bus_word(FN_WRITE, REG_ROUTE3, 32'h04050607));
    issue_word(bus_word(FN_WRITE, REG_RISE_EN, 32'hFFFFFFFF));
    issue_word(bus_word(FN_WRITE, REG_FALL_EN, 32'h0000FFFF));
    issue_word(bus_word(FN_WRITE, REG_MASK, 32'hFFFFFFFF));
    pins = '1;
    issue_word(tick_word(pins));
    pins = '0;
    issue_word(tick_word(pins));
    pins = '1;
    issue_word(tick_word(pins));
    issue_word(bus_word(FN_READ, REG_RISE_PEND, 32'h0));
    issue_word(bus_word(FN_READ, REG_FALL_PEND, 32'h0));
    issue_word(bus_word(FN_WRITE, REG_RISE_PEND, 32'hFFFFFFFF));
    issue_word(bus_word(FN_WRITE, REG_FALL_PEND, 32'h000000FF));
    issue_word(bus_word(FN_READ, REG_NONE_LO, 32'hFFFFFFFF));
    issue_word(bus_word(FN_READ, REG_NONE_HI, 32'h0));
    issue_word(bus_word(FN_WRITE, REG_NONE_HI, 32'hFFFFFFFF));
    issue_word(bus_word(FN_UNUSED, REG_MASK, 32'hFFFFFFFF));
    issue_word(bus_word(FN_READ, REG_ROUTE2, 32'h0));
    issue_word(bus_word(FN_READ, REG_ROUTE3, 32'h0));
    issue_word(bus_word(FN_READ, REG_RISE_EN, 32'h0));
    issue_word(bus_word(FN_READ, REG_FALL_EN, 32'h0));
    issue_word(bus_word(FN_READ, REG_MASK, 32'h0));
    issue_word(bus_word(FN_WRITE, REG_MASK, 32'h0));

    // Random part: mostly samples and legal register traffic.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Usually flip a few pins so that edges stay sparse and traceable.
        if ($urandom_range(0, 9) < 7) begin
          for (p = 0; p < 8; p++) pins[p] = pins[p] ^ 16'($urandom & $urandom);
        end else begin
          for (p = 0; p < 8; p++) pins[p] = 16'($urandom);
        end
        issue_word(tick_word(pins));
      end else if (pick < 65) begin
        s = 4'($urandom_range(REG_RISE_EN, REG_ROUTE3));
        issue_word(bus_word(FN_READ, s, $urandom));
      end else if (pick < 90) begin
        s = 4'($urandom_range(REG_RISE_EN, REG_ROUTE3));
        if (s >= REG_ROUTE0) begin
          for (j = 0; j < 4; j++) begin
            d[8*j +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, PORT_COUNT - 1));
          end
        end else begin
          d = ($urandom_range(0, 3) == 0) ? 32'hFFFFFFFF : $urandom;
        end
        issue_word(bus_word(FN_WRITE, s, d));
      end else if (pick < 95) begin
        s = 4'($urandom_range(REG_NONE_LO, REG_NONE_HI));
        issue_word(bus_word($urandom_range(0, 1) ? FN_READ : FN_WRITE, s, $urandom));
      end else begin
        issue_word(bus_word(FN_UNUSED, 4'($urandom), $urandom));
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (mirror.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.errors == 0 && mirror.replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
